// ===== sv/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, widths and constants of the advection-diffusion residual block.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int ADSR_MAX_COLUMNS = 1024;

   localparam int SAMPLE_W  = 48;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 16;
   localparam int EPS_W     = 47;
   localparam int GC_W      = 11;
   localparam int STEP_W    = 26;
   localparam int RECIP_W   = 48;
   localparam int WORD_W    = 64;
   localparam int PROD_W    = 128;
   localparam int CHUNK_W   = 16;
   localparam int PP_W      = WORD_W + CHUNK_W;
   localparam int APB_W     = 64;
   localparam int ADDR_W    = 6;
   localparam int REG_IDX_W = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [REG_IDX_W-1:0] REG_EPS  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COLS = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROWS = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STPX = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STPY = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_INVX = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_INVY = 3'd6;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [WORD_W-1:0]   word_type;

   localparam word_type   Q_ONE     = 64'sd16777216;
   localparam logic [WORD_W-1:0] MID_LIM = 64'h1000_0000_0000_0000;
   localparam word_type   OUT_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam word_type   OUT_MIN   = 64'shFFFF_8000_0000_0000;
   localparam sample_type MINUS_ONE = 48'shFFFF_FF00_0000;

   typedef struct packed {
      logic [EPS_W-1:0]   eps;
      logic [ROW_W-1:0]   rows;
      logic [STEP_W-1:0]  step_x;
      logic [STEP_W-1:0]  step_y;
      logic [EPS_W-1:0]   isx;
      logic [EPS_W-1:0]   isy;
      logic [RECIP_W-1:0] hrx;
      logic [RECIP_W-1:0] hry;
      logic               busy;
   } cfg_type;

   typedef struct packed {
      logic              has_upper;
      logic              upper_interior;
      logic              has_own;
      sample_type        upper_bval;
      sample_type        own_bval;
      logic [ROW_W-1:0]  upper_row;
      logic [ROW_W-1:0]  own_row;
      logic [COL_W-1:0]  column;
      sample_type        u;
      sample_type        left;
      sample_type        cen;
      sample_type        right;
      sample_type        down;
      sample_type        x;
      sample_type        y;
   } entry_type;

   function automatic sample_type sat48(word_type v);
      sample_type r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[SAMPLE_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/adsr_channels.sv =====
// ----------------------------------------------------------------------------
// adsr channels
// Valid/ready channel bundles for samples and residual results.
// ----------------------------------------------------------------------------
interface adsr_req_if import adsr_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*; ();
   logic             valid;
   logic             ready;
   sample_type       residual;
   logic [COL_W-1:0] column;
   logic [ROW_W-1:0] row;
   logic             last;
   modport source (output valid, output residual, output column, output row,
                   output last, input ready);
   modport sink   (input valid, input residual, input column, input row,
                   input last, output ready);
endinterface

// ===== sv/adsr_csr.sv =====
// ----------------------------------------------------------------------------
// adsr_csr
// Register file with APB write/read and a bit-serial divider for 1/(2h).
// ----------------------------------------------------------------------------
module adsr_csr import adsr_pkg::*; #(
   parameter int MAX_COLUMNS = ADSR_MAX_COLUMNS,
   localparam int CW1 = $clog2(MAX_COLUMNS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [APB_W-1:0]  pwdata,
   output logic [APB_W-1:0]  prdata,
   output logic              pready,
   output cfg_type           cfg,
   output logic [CW1-1:0]    cols_eff
);

   localparam int DIV_STEPS = 48;
   localparam int DCNT_W = $clog2(DIV_STEPS);

   logic [EPS_W-1:0]   eps_ff, isx_ff, isy_ff;
   logic [GC_W-1:0]    cols_ff;
   logic [ROW_W-1:0]   rows_ff;
   logic [STEP_W-1:0]  sx_ff, sy_ff;
   logic [RECIP_W-1:0] hrx_ff, hry_ff;
   logic               pend_x_ff, pend_y_ff, div_busy_ff, div_sel_ff;
   logic [DCNT_W-1:0]  div_cnt_ff;
   logic [STEP_W-1:0]  div_rem_ff;
   logic [RECIP_W-1:0] div_q_ff;

   logic                 wr;
   logic [REG_IDX_W-1:0] idx;
   logic [STEP_W-1:0]    div_d;
   logic [STEP_W:0]      rem_sh, rem_in;
   logic                 ge;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

   assign div_d  = div_sel_ff ? sy_ff : sx_ff;
   assign rem_sh = {div_rem_ff, (div_cnt_ff == '0)};
   assign ge     = rem_sh >= {1'b0, div_d};
   assign rem_in = ge ? rem_sh - {1'b0, div_d} : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff      <= EPS_W'(Q_ONE);
         cols_ff     <= GC_W'(3);
         rows_ff     <= ROW_W'(3);
         sx_ff       <= STEP_W'(Q_ONE);
         sy_ff       <= STEP_W'(Q_ONE);
         isx_ff      <= EPS_W'(Q_ONE);
         isy_ff      <= EPS_W'(Q_ONE);
         hrx_ff      <= RECIP_W'(Q_ONE >>> 1);
         hry_ff      <= RECIP_W'(Q_ONE >>> 1);
         pend_x_ff   <= 1'b0;
         pend_y_ff   <= 1'b0;
         div_busy_ff <= 1'b0;
         div_sel_ff  <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         if (div_busy_ff) begin
            div_rem_ff <= rem_in[STEP_W-1:0];
            div_q_ff   <= {div_q_ff[RECIP_W-2:0], ge};
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (32'(div_cnt_ff) == DIV_STEPS - 1) begin
               div_busy_ff <= 1'b0;
               if (div_sel_ff) begin
                  hry_ff <= {div_q_ff[RECIP_W-2:0], ge};
               end else begin
                  hrx_ff <= {div_q_ff[RECIP_W-2:0], ge};
               end
            end
         end else if (pend_x_ff) begin
            pend_x_ff <= 1'b0;
            if (sx_ff == '0) begin
               hrx_ff <= RECIP_W'(1) << (RECIP_W - 1);
            end else begin
               div_busy_ff <= 1'b1;
               div_sel_ff  <= 1'b0;
               div_cnt_ff  <= '0;
               div_rem_ff  <= '0;
               div_q_ff    <= '0;
            end
         end else if (pend_y_ff) begin
            pend_y_ff <= 1'b0;
            if (sy_ff == '0) begin
               hry_ff <= RECIP_W'(1) << (RECIP_W - 1);
            end else begin
               div_busy_ff <= 1'b1;
               div_sel_ff  <= 1'b1;
               div_cnt_ff  <= '0;
               div_rem_ff  <= '0;
               div_q_ff    <= '0;
            end
         end
         if (wr) begin
            unique case (idx)
               REG_EPS:  eps_ff  <= pwdata[EPS_W-1:0];
               REG_COLS: cols_ff <= pwdata[GC_W-1:0];
               REG_ROWS: rows_ff <= pwdata[ROW_W-1:0];
               REG_STPX: begin
                  sx_ff     <= pwdata[STEP_W-1:0];
                  pend_x_ff <= 1'b1;
               end
               REG_STPY: begin
                  sy_ff     <= pwdata[STEP_W-1:0];
                  pend_y_ff <= 1'b1;
               end
               REG_INVX: isx_ff  <= pwdata[EPS_W-1:0];
               REG_INVY: isy_ff  <= pwdata[EPS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (idx)
         REG_EPS:  prdata = APB_W'(eps_ff);
         REG_COLS: prdata = APB_W'(cols_ff);
         REG_ROWS: prdata = APB_W'(rows_ff);
         REG_STPX: prdata = APB_W'(sx_ff);
         REG_STPY: prdata = APB_W'(sy_ff);
         REG_INVX: prdata = APB_W'(isx_ff);
         REG_INVY: prdata = APB_W'(isy_ff);
         default:  prdata = '0;
      endcase
   end

   always_comb begin
      if (cols_ff < GC_W'(2)) begin
         cols_eff = CW1'(2);
      end else if (32'(cols_ff) > MAX_COLUMNS) begin
         cols_eff = CW1'(MAX_COLUMNS);
      end else begin
         cols_eff = CW1'(cols_ff);
      end
   end

   always_comb begin
      cfg.eps    = eps_ff;
      cfg.rows   = (rows_ff < ROW_W'(2)) ? ROW_W'(2) : rows_ff;
      cfg.step_x = sx_ff;
      cfg.step_y = sy_ff;
      cfg.isx    = isx_ff;
      cfg.isy    = isy_ff;
      cfg.hrx    = hrx_ff;
      cfg.hry    = hry_ff;
      cfg.busy   = pend_x_ff || pend_y_ff || div_busy_ff;
   end

endmodule

// ===== sv/adsr_front.sv =====
// ----------------------------------------------------------------------------
// adsr_front
// Accept samples, walk the raster, keep the two line stores and classify
// each point as boundary or interior for the back end.
// ----------------------------------------------------------------------------
module adsr_front import adsr_pkg::*; #(
   parameter int MAX_COLUMNS = ADSR_MAX_COLUMNS,
   localparam int CW  = $clog2(MAX_COLUMNS),
   localparam int CW1 = $clog2(MAX_COLUMNS + 1)
) (
   input  logic           clock,
   input  logic           reset,
   adsr_req_if.sink       req_chan,
   input  cfg_type        cfg,
   input  logic [CW1-1:0] cols_eff,
   input  logic           q_full,
   output logic           push,
   output entry_type      push_entry
);

   localparam logic FS_IDLE = 1'b0;
   localparam logic FS_READ = 1'b1;

   logic             state_ff;
   logic [CW-1:0]    col_ff, i_ff;
   logic [ROW_W-1:0] row_ff, j_ff;
   sample_type       cx_ff, cy_ff, held_ff;
   sample_type       u_ff, x_ff, y_ff, left_ff;
   sample_type       rd_c_ff, rd_r_ff, rd_d_ff;

   logic [SAMPLE_W-1:0] newer_mem [MAX_COLUMNS];
   logic [SAMPLE_W-1:0] older_mem [MAX_COLUMNS];

   logic             accept, col_wrap, row_wrap;
   logic [CW-1:0]    ip1;
   logic             last_col, has_upper, has_own, interior;
   logic [ROW_W-1:0] r;

   assign req_chan.ready = (state_ff == FS_IDLE) && !q_full && !cfg.busy;
   assign accept   = req_chan.valid && req_chan.ready;
   assign col_wrap = (32'(col_ff) + 1) >= 32'(cols_eff);
   assign row_wrap = (32'(row_ff) + 1) >= 32'(cfg.rows);
   assign ip1      = ((32'(col_ff) + 1) == MAX_COLUMNS) ? '0 : col_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         cx_ff    <= MINUS_ONE;
         cy_ff    <= MINUS_ONE;
         held_ff  <= '0;
      end else begin
         unique case (state_ff)
            FS_IDLE: begin
               if (accept) begin
                  state_ff <= FS_READ;
                  if (col_wrap) begin
                     col_ff <= '0;
                     cx_ff  <= MINUS_ONE;
                     if (row_wrap) begin
                        row_ff <= '0;
                        cy_ff  <= MINUS_ONE;
                     end else begin
                        row_ff <= row_ff + 1'b1;
                        cy_ff  <= cy_ff + SAMPLE_W'(cfg.step_y);
                     end
                  end else begin
                     col_ff <= col_ff + 1'b1;
                     cx_ff  <= cx_ff + SAMPLE_W'(cfg.step_x);
                  end
               end
            end
            FS_READ: begin
               state_ff <= FS_IDLE;
               held_ff  <= rd_c_ff;
            end
            default: state_ff <= FS_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         u_ff    <= req_chan.sample;
         i_ff    <= col_ff;
         j_ff    <= row_ff;
         x_ff    <= cx_ff;
         y_ff    <= cy_ff - SAMPLE_W'(cfg.step_y);
         left_ff <= held_ff;
         rd_c_ff <= newer_mem[col_ff];
         rd_r_ff <= newer_mem[ip1];
         rd_d_ff <= older_mem[col_ff];
      end
      if (state_ff == FS_READ) begin
         older_mem[i_ff] <= rd_c_ff;
         newer_mem[i_ff] <= u_ff;
      end
   end

   always_comb begin
      last_col  = 32'(i_ff) >= (32'(cols_eff) - 1);
      r         = j_ff - 1'b1;
      has_upper = j_ff >= ROW_W'(2);
      has_own   = (j_ff == '0) || (32'(j_ff) >= (32'(cfg.rows) - 1));
      interior  = !((i_ff == '0) || last_col || (32'(r) >= (32'(cfg.rows) - 1)));
      push      = (state_ff == FS_READ) && (has_upper || has_own);

      push_entry.has_upper      = has_upper;
      push_entry.upper_interior = interior;
      push_entry.has_own        = has_own;
      push_entry.upper_bval     = last_col ? sat48(WORD_W'(rd_c_ff) - Q_ONE) : rd_c_ff;
      push_entry.own_bval       = last_col ? sat48(WORD_W'(u_ff) - Q_ONE) : u_ff;
      push_entry.upper_row      = r;
      push_entry.own_row        = j_ff;
      push_entry.column         = COL_W'(i_ff);
      push_entry.u              = u_ff;
      push_entry.left           = left_ff;
      push_entry.cen            = rd_c_ff;
      push_entry.right          = rd_r_ff;
      push_entry.down           = rd_d_ff;
      push_entry.x              = x_ff;
      push_entry.y              = y_ff;
   end

endmodule

// ===== sv/adsr_queue.sv =====
// ----------------------------------------------------------------------------
// adsr_queue
// Short queue of classified points between front and back end.
// ----------------------------------------------------------------------------
module adsr_queue import adsr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type       slots [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, rp_ff;
   logic [PW:0]     cnt_ff;

   assign full  = 32'(cnt_ff) == QUEUE_DEPTH;
   assign empty = cnt_ff == '0;
   assign head  = slots[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= (32'(wp_ff) == QUEUE_DEPTH - 1) ? '0 : wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= (32'(rp_ff) == QUEUE_DEPTH - 1) ? '0 : rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wp_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/adsr_back.sv =====
// ----------------------------------------------------------------------------
// adsr_back
// Evaluate the stencil with one shared chunked multiplier and drive results.
// ----------------------------------------------------------------------------
module adsr_back import adsr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_empty,
   input  entry_type q_head,
   output logic      pop,
   adsr_rsp_if.source rsp_chan
);

   localparam logic [2:0] BS_IDLE = 3'd0;
   localparam logic [2:0] BS_MUL  = 3'd1;
   localparam logic [2:0] BS_SUM  = 3'd2;
   localparam logic [2:0] BS_UP   = 3'd3;
   localparam logic [2:0] BS_OWN  = 3'd4;

   localparam logic [3:0] ST_XX  = 4'd0;
   localparam logic [3:0] ST_YY  = 4'd1;
   localparam logic [3:0] ST_WX  = 4'd2;
   localparam logic [3:0] ST_WY  = 4'd3;
   localparam logic [3:0] ST_UXX = 4'd4;
   localparam logic [3:0] ST_UYY = 4'd5;
   localparam logic [3:0] ST_PX  = 4'd6;
   localparam logic [3:0] ST_ADX = 4'd7;
   localparam logic [3:0] ST_PY  = 4'd8;
   localparam logic [3:0] ST_ADY = 4'd9;
   localparam logic [3:0] ST_EPS = 4'd10;
   localparam int NSTEPS = 11;

   localparam logic [2:0] MC_LOAD = 3'd0;
   localparam logic [2:0] MC_FIN  = 3'd5;

   logic [2:0]        state_ff;
   entry_type         cur_ff;
   logic [3:0]        step_ff;
   logic [2:0]        mcnt_ff;
   logic [WORD_W-1:0] ua_ff, ub_ff;
   logic              neg_ff;
   logic [PROD_W-1:0] acc_ff;
   word_type          t_ff [NSTEPS];
   sample_type        upres_ff;

   logic              rsp_valid_ff, last_ff;
   sample_type        residual_ff;
   logic [COL_W-1:0]  column_ff;
   logic [ROW_W-1:0]  row_ff;

   word_type          op_a, op_b;
   logic [PP_W-1:0]   pp;
   logic [WORD_W-1:0] qmag;
   logic              slot_free;
   logic              emit;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.residual = residual_ff;
   assign rsp_chan.column   = column_ff;
   assign rsp_chan.row      = row_ff;
   assign rsp_chan.last     = last_ff;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = slot_free && (((state_ff == BS_UP) && cur_ff.has_upper)
                                    || (state_ff == BS_OWN));
   assign pop       = (state_ff == BS_IDLE) && !q_empty;
   assign pp        = PP_W'(ua_ff) * PP_W'(ub_ff[WORD_W-1:WORD_W-CHUNK_W]);
   assign qmag      = (|acc_ff[PROD_W-1:84]) ? MID_LIM : WORD_W'(acc_ff[83:24]);

   always_comb begin
      case (step_ff)
         ST_XX: begin
            op_a = WORD_W'(cur_ff.x);
            op_b = WORD_W'(cur_ff.x);
         end
         ST_YY: begin
            op_a = WORD_W'(cur_ff.y);
            op_b = WORD_W'(cur_ff.y);
         end
         ST_WX: begin
            op_a = WORD_W'(cur_ff.y);
            op_b = Q_ONE - t_ff[ST_XX];
         end
         ST_WY: begin
            op_a = WORD_W'(cur_ff.x);
            op_b = Q_ONE - t_ff[ST_YY];
         end
         ST_UXX: begin
            op_a = WORD_W'(cur_ff.left) - (WORD_W'(cur_ff.cen) <<< 1)
                 + WORD_W'(cur_ff.right);
            op_b = WORD_W'(cfg.isx);
         end
         ST_UYY: begin
            op_a = WORD_W'(cur_ff.down) - (WORD_W'(cur_ff.cen) <<< 1)
                 + WORD_W'(cur_ff.u);
            op_b = WORD_W'(cfg.isy);
         end
         ST_PX: begin
            op_a = t_ff[ST_WX] <<< 1;
            op_b = WORD_W'(cur_ff.right) - WORD_W'(cur_ff.left);
         end
         ST_ADX: begin
            op_a = t_ff[ST_PX];
            op_b = WORD_W'(cfg.hrx);
         end
         ST_PY: begin
            op_a = -(t_ff[ST_WY] <<< 1);
            op_b = WORD_W'(cur_ff.u) - WORD_W'(cur_ff.down);
         end
         ST_ADY: begin
            op_a = t_ff[ST_PY];
            op_b = WORD_W'(cfg.hry);
         end
         ST_EPS: begin
            op_a = WORD_W'(cfg.eps);
            op_b = t_ff[ST_UXX] + t_ff[ST_UYY];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         step_ff      <= ST_XX;
         mcnt_ff      <= MC_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            BS_IDLE: begin
               if (!q_empty) begin
                  cur_ff  <= q_head;
                  step_ff <= ST_XX;
                  mcnt_ff <= MC_LOAD;
                  state_ff <= (q_head.has_upper && q_head.upper_interior) ? BS_MUL : BS_UP;
               end
            end
            BS_MUL: begin
               if (mcnt_ff == MC_LOAD) begin
                  ua_ff   <= op_a[WORD_W-1] ? -op_a : op_a;
                  ub_ff   <= op_b[WORD_W-1] ? -op_b : op_b;
                  neg_ff  <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
                  acc_ff  <= '0;
                  mcnt_ff <= mcnt_ff + 1'b1;
               end else if (mcnt_ff == MC_FIN) begin
                  t_ff[step_ff] <= neg_ff ? -word_type'(qmag) : word_type'(qmag);
                  mcnt_ff <= MC_LOAD;
                  if (step_ff == ST_EPS) begin
                     state_ff <= BS_SUM;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end else begin
                  acc_ff  <= (acc_ff << CHUNK_W) + PROD_W'(pp);
                  ub_ff   <= ub_ff << CHUNK_W;
                  mcnt_ff <= mcnt_ff + 1'b1;
               end
            end
            BS_SUM: begin
               upres_ff <= sat48(t_ff[ST_ADX] + t_ff[ST_ADY] - t_ff[ST_EPS]);
               state_ff <= BS_UP;
            end
            BS_UP: begin
               if (!cur_ff.has_upper) begin
                  state_ff <= BS_OWN;
               end else if (slot_free) begin
                  residual_ff  <= cur_ff.upper_interior ? upres_ff : cur_ff.upper_bval;
                  column_ff    <= cur_ff.column;
                  row_ff       <= cur_ff.upper_row;
                  last_ff      <= !cur_ff.has_own;
                  state_ff     <= cur_ff.has_own ? BS_OWN : BS_IDLE;
               end
            end
            BS_OWN: begin
               if (slot_free) begin
                  residual_ff  <= cur_ff.own_bval;
                  column_ff    <= cur_ff.column;
                  row_ff       <= cur_ff.own_row;
                  last_ff      <= 1'b1;
                  state_ff     <= BS_IDLE;
               end
            end
            default: state_ff <= BS_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/advection_diffusion_stencil_residual.sv =====
// ----------------------------------------------------------------------------
// advection_diffusion_stencil_residual
// Streaming five-point residual of a steady advection-diffusion problem.
//
// Samples enter on req_chan in raster order, one beat per grid point. Each
// beat yields zero, one or two result beats on rsp_chan; last marks the
// final one. Row 0 is reported at once, row r while row r+1 streams in, and
// the last row reports the point above and its own point per beat.
// The front end reads the line stores on accepting a beat and writes them
// back in FS_READ, taking no new beat meanwhile. Boundary points go from
// dequeue straight to the output register; an interior point first makes
// eleven passes through the shared 64x16 chunked multiplier.
// A two-entry queue between front and back end and the rsp output register
// let the front keep accepting while rsp is stalled.
// Writing step_x or step_y starts a reciprocal division; req_chan
// is held off until it completes. Reset clears counters, sets coordinates
// to -1.0 and registers to defaults; line store contents are undefined.
// Configure only while no beat is in flight.
// ----------------------------------------------------------------------------
module advection_diffusion_stencil_residual import adsr_pkg::*; #(
   parameter int MAX_COLUMNS = ADSR_MAX_COLUMNS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [APB_W-1:0]  pwdata,
   output logic [APB_W-1:0]  prdata,
   output logic              pready,
   adsr_req_if.sink          req_chan,
   adsr_rsp_if.source        rsp_chan
);

   localparam int CW1 = $clog2(MAX_COLUMNS + 1);

   cfg_type        cfg;
   logic [CW1-1:0] cols_eff;
   logic           push, pop, q_full, q_empty;
   entry_type      push_entry, q_head;

   adsr_csr #(.MAX_COLUMNS(MAX_COLUMNS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .cols_eff (cols_eff)
   );

   adsr_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .cols_eff   (cols_eff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   adsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   adsr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== bench/tb_advection_diffusion_stencil_residual.sv =====
// ----------------------------------------------------------------------------
// tb_advection_diffusion_stencil_residual
// Self-checking bench for the streaming advection-diffusion residual block.
// Samples go in over the req channel with random gaps. Every accepted beat
// updates a predictor of the stencil, which queues the residuals that beat
// should produce. Each rsp beat is checked against the oldest one, field by
// field. The register port sweeps grid sizes, spacings and coefficients,
// extremes and out-of-range values included. Some changes land mid-frame.
// ----------------------------------------------------------------------------
module tb_advection_diffusion_stencil_residual;
   import adsr_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] residual;
      logic [COL_W-1:0]           column;
      logic [ROW_W-1:0]           row;
      logic                       last;
   } residual_beat_t;

   typedef struct {
      longint sample;
      bit     typed;
      longint residual;
   } directed_row_t;

   localparam longint Q1 = 64'sd16777216;
   localparam longint SMAX = (64'sd1 <<< 47) - 1;
   localparam longint SMIN = -(64'sd1 <<< 47);
   localparam longint EPS_MAX = (64'sd1 <<< 47) - 1;
   localparam longint STEP_MAX = 64'sd33554432;
   localparam int ITEM_TARGET = 1900;
   localparam int SETTLE = 120;

   logic clock, reset;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [APB_W-1:0] pwdata, prdata;
   logic pready;

   adsr_req_if req_bus ();
   adsr_rsp_if rsp_bus ();

   advection_diffusion_stencil_residual uut (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_chan(req_bus.sink), .rsp_chan(rsp_bus.source)
   );

   // stencil mirror
   longint older_line [ADSR_MAX_COLUMNS];
   longint newer_line [ADSR_MAX_COLUMNS];
   int     col_ctr, row_ctr;
   longint coord_x, coord_y, held_left;
   longint eps_r, cols_r, rows_r, stx_r, sty_r, isx_r, isy_r;

   residual_beat_t pending_residuals[$];
   int  errors, samples_in, residuals_out, csr_writes;
   bit  feeding_done;
   int  typed_pending;
   longint typed_value;

   function automatic longint sx48(longint v);
      logic signed [47:0] t;
      t = v[47:0];
      return t;
   endfunction

   function automatic longint sat48(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      logic [63:0]  q;
      ua = (a < 0) ? 64'd0 - a : a;
      ub = (b < 0) ? 64'd0 - b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p >> 24;
      q = (p > 128'h1000_0000_0000_0000) ? 64'h1000_0000_0000_0000 : p[63:0];
      return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint half_recip(longint h);
      if (h == 0) return 64'sd1 <<< 47;
      return (64'sd1 <<< 47) / h;
   endfunction

   function automatic int grid_cols();
      if (cols_r < 2) return 2;
      if (cols_r > ADSR_MAX_COLUMNS) return ADSR_MAX_COLUMNS;
      return int'(cols_r);
   endfunction

   function automatic int grid_rows();
      return (rows_r < 2) ? 2 : int'(rows_r);
   endfunction

   function automatic longint edge_value(longint u, int i, int cols);
      return (i >= cols - 1) ? sat48(u - Q1) : u;
   endfunction

   function automatic void push_residual(longint r, int i, int j);
      residual_beat_t b;
      b.residual = r[47:0];
      b.column = i[COL_W-1:0];
      b.row = j[ROW_W-1:0];
      b.last = 1'b0;
      pending_residuals.push_back(b);
   endfunction

   function automatic void predict_residuals(longint u);
      int cols, rows, i, j, n;
      longint c, res, left, right, down, x, y, wx, wy, uxx, uyy, adx, ady;
      cols = grid_cols();
      rows = grid_rows();
      i = col_ctr % ADSR_MAX_COLUMNS;
      j = row_ctr;
      n = 0;
      if (j == 0) begin
         push_residual(edge_value(u, i, cols), i, 0);
         n++;
      end else begin
         if (j >= 2) begin
            c = newer_line[i];
            if (i == 0 || i >= cols - 1 || j - 1 >= rows - 1) begin
               res = edge_value(c, i, cols);
            end else begin
               left = held_left;
               right = newer_line[(i + 1) % ADSR_MAX_COLUMNS];
               down = older_line[i];
               x = coord_x;
               y = sx48(coord_y - sty_r);
               wx = 2 * qmul(y, Q1 - qmul(x, x));
               wy = -2 * qmul(x, Q1 - qmul(y, y));
               uxx = qmul(left - 2 * c + right, isx_r);
               uyy = qmul(down - 2 * c + u, isy_r);
               adx = qmul(qmul(wx, right - left), half_recip(stx_r));
               ady = qmul(qmul(wy, u - down), half_recip(sty_r));
               res = sat48(-qmul(eps_r, uxx + uyy) + adx + ady);
            end
            push_residual(res, i, j - 1);
            n++;
         end
         if (j >= rows - 1) begin
            push_residual(edge_value(u, i, cols), i, j);
            n++;
         end
      end
      if (n > 0) pending_residuals[$].last = 1'b1;
      held_left = newer_line[i];
      older_line[i] = newer_line[i];
      newer_line[i] = u;
      if (col_ctr + 1 >= cols) begin
         col_ctr = 0;
         coord_x = -Q1;
         if (row_ctr + 1 >= rows) begin
            row_ctr = 0;
            coord_y = -Q1;
         end else begin
            row_ctr++;
            coord_y = sx48(coord_y + sty_r);
         end
      end else begin
         col_ctr++;
         coord_x = sx48(coord_x + stx_r);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("*** FAILED ***");
      $finish;
   end

   // accept monitor
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_residuals(longint'(req_bus.sample));
         samples_in++;
         if (typed_pending > 0) begin
            pending_residuals[$].residual = typed_value[47:0];
            typed_pending = 0;
         end
      end
   end

   // residual checker
   always @(posedge clock) begin
      residual_beat_t e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         residuals_out++;
         if (pending_residuals.size() == 0) begin
            $error("unexpected residual beat col %0d row %0d", rsp_bus.column, rsp_bus.row);
            errors++;
         end else begin
            e = pending_residuals.pop_front();
            if (rsp_bus.residual !== e.residual) begin
               $error("residual: expected %0d, got %0d", e.residual, rsp_bus.residual);
               errors++;
            end
            if (rsp_bus.column !== e.column) begin
               $error("column: expected %0d, got %0d", e.column, rsp_bus.column);
               errors++;
            end
            if (rsp_bus.row !== e.row) begin
               $error("row: expected %0d, got %0d", e.row, rsp_bus.row);
               errors++;
            end
            if (rsp_bus.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_bus.last);
               errors++;
            end
         end
      end
   end

   // result-side backpressure
   bit rsp_no_stall;
   initial begin
      int g;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         g = rsp_no_stall ? 0 : $urandom_range(0, 14);
         if (g > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   bit req_no_gap;
   task automatic send_sample(longint s);
      int g;
      g = req_no_gap ? 0 : $urandom_range(0, 14);
      if (g > 0) begin
         req_bus.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.sample = s[47:0];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_residuals.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, longint value);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 3'b000};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      csr_writes++;
      case (idx)
         REG_EPS:  eps_r = value & EPS_MAX;
         REG_COLS: cols_r = value & 64'h7ff;
         REG_ROWS: rows_r = value & 64'hffff;
         REG_STPX: stx_r = value & 64'h3ff_ffff;
         REG_STPY: sty_r = value & 64'h3ff_ffff;
         REG_INVX: isx_r = value & EPS_MAX;
         REG_INVY: isy_r = value & EPS_MAX;
         default: ;
      endcase
   endtask

   function automatic longint rand_sample();
      case ($urandom_range(0, 3))
         0: return sx48({$urandom, $urandom});
         default: return longint'($urandom_range(0, 32'h07ff_ffff)) - 64'sd67108864;
      endcase
   endfunction

   function automatic longint pick_step();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return STEP_MAX;
         default: return $urandom_range(1, 33554432);
      endcase
   endfunction

   function automatic longint pick_wide();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return EPS_MAX;
         default: return $urandom_range(1, 32'h3fff_ffff);
      endcase
   endfunction

   directed_row_t directed[] = '{
      '{SMAX, 1, SMAX}, '{SMIN, 1, SMIN}, '{SMIN, 1, SMIN},
      '{SMIN, 0, 0}, '{SMAX, 0, 0}, '{SMIN, 0, 0},
      '{SMAX, 0, 0}, '{SMIN, 0, 0}, '{SMAX, 0, 0},
      '{0, 1, 0}, '{Q1, 1, Q1}, '{0, 1, -Q1},
      '{Q1, 0, 0}, '{-Q1, 0, 0}, '{2 * Q1, 0, 0},
      '{3 * Q1, 0, 0}, '{-Q1, 0, 0}, '{SMAX, 0, 0}
   };

   initial begin
      int phase, n, cols, rows, extra, newcols;
      bit at_origin;
      errors = 0;
      samples_in = 0;
      residuals_out = 0;
      csr_writes = 0;
      typed_pending = 0;
      feeding_done = 0;
      rsp_no_stall = 0;
      req_no_gap = 0;
      foreach (older_line[k]) begin
         older_line[k] = 0;
         newer_line[k] = 0;
      end
      col_ctr = 0;
      row_ctr = 0;
      coord_x = -Q1;
      coord_y = -Q1;
      held_left = 0;
      eps_r = Q1;
      cols_r = 3;
      rows_r = 3;
      stx_r = Q1;
      sty_r = Q1;
      isx_r = Q1;
      isy_r = Q1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[k]) begin
         typed_pending = directed[k].typed;
         typed_value = directed[k].residual;
         send_sample(directed[k].sample);
      end
      wait_drained();

      phase = 0;
      while (samples_in < ITEM_TARGET) begin
         at_origin = (col_ctr == 0 && row_ctr == 0);
         cols = $urandom_range(2, 8);
         rows = $urandom_range(2, 6);
         if (phase == 2) cols = 0;
         if (phase == 3) rows = 1;
         if (phase == 4) cols = 2047;
         if (phase == 7) rows = 65535;
         newcols = cols < 2 ? 2 : (cols > ADSR_MAX_COLUMNS ? ADSR_MAX_COLUMNS : cols);
         if (!at_origin && newcols > grid_cols()) cols = grid_cols();
         csr_write(REG_EPS, phase == 1 ? EPS_MAX : (phase == 5 ? 1 : pick_wide() | 1));
         csr_write(REG_COLS, cols);
         csr_write(REG_ROWS, rows);
         csr_write(REG_STPX, phase == 1 ? STEP_MAX : pick_step());
         csr_write(REG_STPY, phase == 1 ? 0 : pick_step());
         csr_write(REG_INVX, pick_wide());
         csr_write(REG_INVY, phase == 5 ? EPS_MAX : pick_wide());
         rsp_no_stall = ($urandom_range(0, 4) == 0);
         req_no_gap = ($urandom_range(0, 4) == 0);
         while (!(col_ctr == 0 && row_ctr == 0)) send_sample(rand_sample());
         cols = grid_cols();
         rows = grid_rows();
         if (phase == 4 || phase == 7) begin
            n = 40;
         end else begin
            n = cols * rows * $urandom_range(1, 3);
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cols * rows - 1) : 0;
            n += extra;
         end
         repeat (n) send_sample(rand_sample());
         wait_drained();
         phase++;
      end
      feeding_done = 1;
      rsp_no_stall = 1;
      wait_drained();

      $display("Streamed %0d samples through %0d register settings (%0d writes),",
               samples_in, phase + 1, csr_writes);
      $display("checked %0d residual beats with random stalls on both channels.",
               residuals_out);
      if (errors == 0 && pending_residuals.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/adsr_pkg.sv
sv/adsr_channels.sv
sv/adsr_csr.sv
sv/adsr_front.sv
sv/adsr_queue.sv
sv/adsr_back.sv
sv/advection_diffusion_stencil_residual.sv
bench/tb_advection_diffusion_stencil_residual.sv
